### sv/pcf_pkg.sv
`default_nettype none
package pcf_pkg;

    // Default values of the top-level parameters.
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int QUAD_MAX_DEF   = 22;
    localparam int CUBIC_MAX_DEF  = 30;
    localparam int AREA_LIMIT_DEF = 5000;

    // Fixed widths. Sample counts are held in KW bits, so they stay below 64, as does the segment count.
    localparam int EPS_W   = 9;
    localparam int KW      = 6;
    localparam int KK_W    = 2 * KW - 1;
    localparam int K4_W    = 2 * KK_W - 1;
    localparam int DEN_W   = 15;
    localparam int AREA_W  = 16;
    localparam int M_W     = KW + EPS_W;
    localparam int M2_W    = 2 * M_W;
    localparam int X_W     = AREA_W + M2_W;
    localparam int XLO_W   = X_W / 2;
    localparam int XHI_W   = X_W - XLO_W;
    localparam int LHS_W   = X_W + M2_W;
    localparam int RHS_W   = AREA_W + K4_W;
    // Epsilon is scaled by 256, so its fourth power carries 32 fraction bits.
    localparam int EPS4_SH = 32;
    localparam int CMP_W   = LHS_W - EPS4_SH;

    localparam logic [EPS_W-1:0] EPS_RESET = 9'd256;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_EPSILON = 1'b0;

    localparam logic [2:0] KIND_MOVE  = 3'd0;
    localparam logic [2:0] KIND_LINE  = 3'd1;
    localparam logic [2:0] KIND_QUAD  = 3'd2;
    localparam logic [2:0] KIND_CUBIC = 3'd3;
    localparam logic [2:0] KIND_CLOSE = 3'd4;

    localparam logic [1:0] OUT_MOVE  = 2'd0;
    localparam logic [1:0] OUT_LINE  = 2'd1;
    localparam logic [1:0] OUT_CLOSE = 2'd2;

    typedef enum logic [2:0] {
        EM_CLOSE  = 3'd0,
        EM_MOVE   = 3'd1,
        EM_ORIGIN = 3'd2,
        EM_LINE   = 3'd3,
        EM_POINT  = 3'd4
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      curve_init;
        logic      cross_mul;
        logic      cross_acc;
        logic      area;
        logic      m2;
        logic      x_mul;
        logic      lhs_mul;
        logic      lhs_sum;
        logic      k_sq;
        logic      k_4;
        logic      k_rhs;
        logic      k_take;
        logic      den1;
        logic      den2;
        logic      w1;
        logic      w2;
        logic      mac;
        logic      div_prep;
        logic      div_step;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
        logic      j_inc;
        logic      set_src_p1;
        logic      set_src_end;
        logic      set_needs;
        logic      clr_needs;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       needs_origin;
        logic       out_free;
        logic       cross_done;
        logic       sat;
        logic       k_pass;
        logic       k_at_max;
        logic       mac_done;
        logic       div_done;
        logic       j_at_n;
    } t_status;

endpackage
`default_nettype wire

### sv/pcf_ctrl.sv
`default_nettype none
module pcf_ctrl import pcf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [24:0] {
        S_IDLE        = 25'h0000001,
        S_DECODE      = 25'h0000002,
        S_EMIT_CLOSE  = 25'h0000004,
        S_EMIT_MOVE   = 25'h0000008,
        S_EMIT_ORIGIN = 25'h0000010,
        S_EMIT_LINE   = 25'h0000020,
        S_CROSS_MUL   = 25'h0000040,
        S_CROSS_ACC   = 25'h0000080,
        S_AREA        = 25'h0000100,
        S_M2          = 25'h0000200,
        S_XMUL        = 25'h0000400,
        S_LHS_MUL     = 25'h0000800,
        S_LHS_SUM     = 25'h0001000,
        S_K_SQ        = 25'h0002000,
        S_K_4         = 25'h0004000,
        S_K_RHS       = 25'h0008000,
        S_K_CMP       = 25'h0010000,
        S_DEN1        = 25'h0020000,
        S_DEN2        = 25'h0040000,
        S_W1          = 25'h0080000,
        S_W2          = 25'h0100000,
        S_MAC         = 25'h0200000,
        S_DIV_PREP    = 25'h0400000,
        S_DIV         = 25'h0800000,
        S_EMIT_PT     = 25'h1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.curve_init = 1'b1;
                case (i_status.kind) inside
                    KIND_CLOSE: n_state = S_EMIT_CLOSE;
                    KIND_MOVE:  n_state = S_EMIT_MOVE;
                    KIND_LINE, KIND_QUAD, KIND_CUBIC: begin
                        if (i_status.needs_origin) begin
                            n_state = S_EMIT_ORIGIN;
                        end else if (i_status.kind == KIND_LINE) begin
                            n_state = S_EMIT_LINE;
                        end else begin
                            n_state = S_CROSS_MUL;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT_CLOSE: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = EM_CLOSE;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.set_needs = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EMIT_MOVE: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_sel   = EM_MOVE;
                    o_cmd.emit_last  = 1'b1;
                    o_cmd.set_src_p1 = 1'b1;
                    o_cmd.clr_needs  = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_EMIT_ORIGIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = EM_ORIGIN;
                    o_cmd.clr_needs = 1'b1;
                    n_state = (i_status.kind == KIND_LINE) ? S_EMIT_LINE : S_CROSS_MUL;
                end
            end
            S_EMIT_LINE: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_sel   = EM_LINE;
                    o_cmd.emit_last  = 1'b1;
                    o_cmd.set_src_p1 = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_CROSS_MUL: begin
                o_cmd.cross_mul = 1'b1;
                n_state         = S_CROSS_ACC;
            end
            S_CROSS_ACC: begin
                o_cmd.cross_acc = 1'b1;
                n_state = i_status.cross_done ? S_AREA : S_CROSS_MUL;
            end
            S_AREA: begin
                o_cmd.area = 1'b1;
                n_state    = S_M2;
            end
            S_M2: begin
                o_cmd.m2 = 1'b1;
                n_state  = S_XMUL;
            end
            S_XMUL: begin
                o_cmd.x_mul = 1'b1;
                n_state     = S_LHS_MUL;
            end
            S_LHS_MUL: begin
                o_cmd.lhs_mul = 1'b1;
                n_state       = S_LHS_SUM;
            end
            S_LHS_SUM: begin
                o_cmd.lhs_sum = 1'b1;
                n_state = i_status.sat ? S_DEN1 : S_K_SQ;
            end
            S_K_SQ: begin
                o_cmd.k_sq = 1'b1;
                n_state    = S_K_4;
            end
            S_K_4: begin
                o_cmd.k_4 = 1'b1;
                n_state   = S_K_RHS;
            end
            S_K_RHS: begin
                o_cmd.k_rhs = 1'b1;
                n_state     = S_K_CMP;
            end
            S_K_CMP: begin
                // The test is monotonic in k, so the search stops at the first failure.
                if (i_status.k_pass) begin
                    o_cmd.k_take = 1'b1;
                    n_state = i_status.k_at_max ? S_DEN1 : S_K_SQ;
                end else begin
                    n_state = S_DEN1;
                end
            end
            S_DEN1: begin
                o_cmd.den1 = 1'b1;
                n_state    = S_DEN2;
            end
            S_DEN2: begin
                o_cmd.den2 = 1'b1;
                n_state    = S_W1;
            end
            S_W1: begin
                o_cmd.w1 = 1'b1;
                n_state  = S_W2;
            end
            S_W2: begin
                o_cmd.w2 = 1'b1;
                n_state  = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                n_state = i_status.mac_done ? S_DIV_PREP : S_MAC;
            end
            S_DIV_PREP: begin
                o_cmd.div_prep = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state = i_status.div_done ? S_EMIT_PT : S_DIV;
            end
            S_EMIT_PT: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = EM_POINT;
                    o_cmd.emit_last = i_status.j_at_n;
                    if (i_status.j_at_n) begin
                        o_cmd.set_src_end = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                        n_state     = S_W1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### sv/pcf_dp.sv
`default_nettype none
module pcf_dp import pcf_pkg::*; #(
    parameter int COORD_BITS        = COORD_BITS_DEF,
    parameter int FRAC_BITS         = FRAC_BITS_DEF,
    parameter int QUAD_MAX_SAMPLES  = QUAD_MAX_DEF,
    parameter int CUBIC_MAX_SAMPLES = CUBIC_MAX_DEF,
    parameter int AREA_LIMIT        = AREA_LIMIT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cmd                         i_cmd,
    output t_status                           o_status,
    input  wire logic [EPS_W-1:0]             i_epsilon,
    input  wire logic [2:0]                   i_kind,
    input  wire logic signed [COORD_BITS-1:0] i_p1_x,
    input  wire logic signed [COORD_BITS-1:0] i_p1_y,
    input  wire logic signed [COORD_BITS-1:0] i_p2_x,
    input  wire logic signed [COORD_BITS-1:0] i_p2_y,
    input  wire logic signed [COORD_BITS-1:0] i_p3_x,
    input  wire logic signed [COORD_BITS-1:0] i_p3_y,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [1:0]                        o_out_kind,
    output logic signed [COORD_BITS-1:0]      o_out_x,
    output logic signed [COORD_BITS-1:0]      o_out_y,
    output logic                              o_last
);

    localparam int CB     = COORD_BITS;
    localparam int S_W    = 2 * CB + 3;
    localparam int ACC_W  = CB + DEN_W + 1;
    localparam int DCNT_W = $clog2(CB);

    // Source points: 0 is the end of the previous move, line or curve.
    logic [2:0]           r_kind;
    logic signed [CB-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    logic                 r_needs;

    logic                 cubic;
    logic [1:0]           pts_last;
    logic [KW-1:0]        maxs;

    // Shoelace sum.
    logic [1:0]             r_e;
    logic signed [CB-1:0]   ax, ay, bx, by;
    logic signed [2*CB-1:0] r_pa, r_pb;
    logic signed [S_W-1:0]  r_s;
    logic [S_W-1:0]         mag, area_full;

    // Sample count search.
    logic                 r_sat;
    logic [AREA_W-1:0]    r_area;
    logic [M_W-1:0]       r_m;
    logic [M2_W-1:0]      r_m2;
    logic [X_W-1:0]       r_xp;
    logic [XLO_W+M2_W-1:0] r_lhs_lo;
    logic [XHI_W+M2_W-1:0] r_lhs_hi;
    logic [LHS_W-1:0]     r_lhs;
    logic [KW-1:0]        r_k, r_best;
    logic [KK_W-1:0]      r_kk;
    logic [K4_W-1:0]      r_k4;
    logic [RHS_W-1:0]     r_rhs;
    logic [KW-1:0]        cnt, nseg;

    // Curve evaluation.
    logic [KK_W-1:0]        r_nn;
    logic [DEN_W-1:0]       r_den;
    logic [KW-1:0]          r_j, wa;
    logic [KK_W-1:0]        r_aa, r_ab, r_bb;
    logic [DEN_W-1:0]       r_w0, r_w1, r_w2, r_w3;
    logic [1:0]             r_mi;
    logic [DEN_W-1:0]       w_sel;
    logic signed [CB-1:0]   px_sel, py_sel;
    logic signed [ACC_W-1:0] prod_x, prod_y, r_acc_x, r_acc_y;
    logic signed [ACC_W-1:0] half_den, den_s, tx, ty;
    logic [ACC_W-1:0]       r_rem_x, r_rem_y, r_dsh;
    logic                   r_sx, r_sy, ge_x, ge_y;
    logic [CB-1:0]          r_qx, r_qy;
    logic [DCNT_W-1:0]      r_dcnt;
    logic signed [CB-1:0]   pt_x, pt_y;

    assign cubic    = (r_kind == KIND_CUBIC);
    assign pts_last = cubic ? 2'd3 : 2'd2;
    assign maxs     = cubic ? KW'(CUBIC_MAX_SAMPLES) : KW'(QUAD_MAX_SAMPLES);

    always_comb begin
        unique case (r_e)
            2'd0: begin ax = r_x0; ay = r_y0; bx = r_x1; by = r_y1; end
            2'd1: begin ax = r_x1; ay = r_y1; bx = r_x2; by = r_y2; end
            2'd2: begin
                ax = r_x2; ay = r_y2;
                bx = cubic ? r_x3 : r_x0;
                by = cubic ? r_y3 : r_y0;
            end
            default: begin ax = r_x3; ay = r_y3; bx = r_x0; by = r_y0; end
        endcase
    end

    assign mag       = r_s[S_W-1] ? S_W'(-r_s) : S_W'(r_s);
    assign area_full = mag >> (2 * FRAC_BITS);

    assign cnt  = r_sat ? maxs : ((r_best < KW'(2)) ? KW'(2) : r_best);
    assign nseg = cnt - KW'(1);
    assign wa   = nseg - r_j;

    always_comb begin
        case (r_mi)
            2'd0:    begin w_sel = r_w0; px_sel = r_x0; py_sel = r_y0; end
            2'd1:    begin w_sel = r_w1; px_sel = r_x1; py_sel = r_y1; end
            2'd2:    begin w_sel = r_w2; px_sel = r_x2; py_sel = r_y2; end
            default: begin w_sel = r_w3; px_sel = r_x3; py_sel = r_y3; end
        endcase
    end

    assign prod_x = ACC_W'($signed({1'b0, w_sel})) * ACC_W'(px_sel);
    assign prod_y = ACC_W'($signed({1'b0, w_sel})) * ACC_W'(py_sel);

    // Round to nearest with ties up: floor((num + floor(den/2)) / den).
    assign half_den = $signed(ACC_W'(r_den >> 1));
    assign den_s    = $signed(ACC_W'(r_den));
    assign tx       = r_acc_x + half_den;
    assign ty       = r_acc_y + half_den;
    assign ge_x     = (r_rem_x >= r_dsh);
    assign ge_y     = (r_rem_y >= r_dsh);
    assign pt_x     = r_sx ? $signed(-r_qx) : $signed(r_qx);
    assign pt_y     = r_sy ? $signed(-r_qy) : $signed(r_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0    <= '0;
            r_y0    <= '0;
            r_needs <= 1'b1;
        end else begin
            if (i_cmd.set_src_p1) begin
                r_x0 <= r_x1;
                r_y0 <= r_y1;
            end else if (i_cmd.set_src_end) begin
                r_x0 <= cubic ? r_x3 : r_x2;
                r_y0 <= cubic ? r_y3 : r_y2;
            end
            if (i_cmd.set_needs) begin
                r_needs <= 1'b1;
            end else if (i_cmd.clr_needs) begin
                r_needs <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_x1   <= i_p1_x;
            r_y1   <= i_p1_y;
            r_x2   <= i_p2_x;
            r_y2   <= i_p2_y;
            r_x3   <= i_p3_x;
            r_y3   <= i_p3_y;
        end
        if (i_cmd.curve_init) begin
            r_e <= '0;
            r_s <= '0;
        end
        if (i_cmd.cross_mul) begin
            r_pa <= ax * by;
            r_pb <= ay * bx;
        end
        if (i_cmd.cross_acc) begin
            r_s <= r_s + S_W'(r_pa) - S_W'(r_pb);
            r_e <= r_e + 2'd1;
        end
        if (i_cmd.area) begin
            r_sat  <= (area_full >= S_W'(AREA_LIMIT));
            r_area <= area_full[AREA_W-1:0];
            r_m    <= M_W'(maxs) * M_W'(i_epsilon);
        end
        if (i_cmd.m2) begin
            r_m2 <= M2_W'(r_m) * M2_W'(r_m);
        end
        if (i_cmd.x_mul) begin
            r_xp <= X_W'(r_area) * X_W'(r_m2);
        end
        if (i_cmd.lhs_mul) begin
            r_lhs_lo <= (XLO_W + M2_W)'(r_xp[XLO_W-1:0]) * (XLO_W + M2_W)'(r_m2);
            r_lhs_hi <= (XHI_W + M2_W)'(r_xp[X_W-1:XLO_W]) * (XHI_W + M2_W)'(r_m2);
        end
        if (i_cmd.lhs_sum) begin
            r_lhs  <= {r_lhs_hi, {XLO_W{1'b0}}} + LHS_W'(r_lhs_lo);
            r_k    <= KW'(1);
            r_best <= '0;
        end
        if (i_cmd.k_sq) begin
            r_kk <= KK_W'(r_k) * KK_W'(r_k);
        end
        if (i_cmd.k_4) begin
            r_k4 <= K4_W'(r_kk) * K4_W'(r_kk);
        end
        if (i_cmd.k_rhs) begin
            r_rhs <= RHS_W'(AREA_W'(AREA_LIMIT)) * RHS_W'(r_k4);
        end
        if (i_cmd.k_take) begin
            r_best <= r_k;
            r_k    <= r_k + KW'(1);
        end
        if (i_cmd.den1) begin
            r_nn <= KK_W'(nseg) * KK_W'(nseg);
        end
        if (i_cmd.den2) begin
            r_den <= cubic ? DEN_W'(DEN_W'(r_nn) * DEN_W'(nseg)) : DEN_W'(r_nn);
            r_j   <= KW'(1);
        end
        if (i_cmd.j_inc) begin
            r_j <= r_j + KW'(1);
        end
        if (i_cmd.w1) begin
            r_aa <= KK_W'(wa) * KK_W'(wa);
            r_ab <= KK_W'(wa) * KK_W'(r_j);
            r_bb <= KK_W'(r_j) * KK_W'(r_j);
        end
        if (i_cmd.w2) begin
            if (cubic) begin
                r_w0 <= DEN_W'(r_aa) * DEN_W'(wa);
                r_w1 <= DEN_W'(r_aa) * DEN_W'(r_j) * DEN_W'(3);
                r_w2 <= DEN_W'(r_ab) * DEN_W'(r_j) * DEN_W'(3);
                r_w3 <= DEN_W'(r_bb) * DEN_W'(r_j);
            end else begin
                r_w0 <= DEN_W'(r_aa);
                r_w1 <= DEN_W'({r_ab, 1'b0});
                r_w2 <= DEN_W'(r_bb);
                r_w3 <= '0;
            end
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_mi    <= '0;
        end
        if (i_cmd.mac) begin
            r_acc_x <= r_acc_x + prod_x;
            r_acc_y <= r_acc_y + prod_y;
            r_mi    <= r_mi + 2'd1;
        end
        if (i_cmd.div_prep) begin
            r_sx    <= tx[ACC_W-1];
            r_sy    <= ty[ACC_W-1];
            r_rem_x <= tx[ACC_W-1] ? ACC_W'(den_s - ACC_W'(1) - tx) : ACC_W'(tx);
            r_rem_y <= ty[ACC_W-1] ? ACC_W'(den_s - ACC_W'(1) - ty) : ACC_W'(ty);
            r_dsh   <= ACC_W'(r_den) << (CB - 1);
            r_qx    <= '0;
            r_qy    <= '0;
            r_dcnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem_x <= ge_x ? r_rem_x - r_dsh : r_rem_x;
            r_rem_y <= ge_y ? r_rem_y - r_dsh : r_rem_y;
            r_qx    <= {r_qx[CB-2:0], ge_x};
            r_qy    <= {r_qy[CB-2:0], ge_y};
            r_dsh   <= r_dsh >> 1;
            r_dcnt  <= r_dcnt + DCNT_W'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_last <= i_cmd.emit_last;
            unique case (i_cmd.emit_sel)
                EM_CLOSE: begin
                    o_out_kind <= OUT_CLOSE;
                    o_out_x    <= '0;
                    o_out_y    <= '0;
                end
                EM_MOVE: begin
                    o_out_kind <= OUT_MOVE;
                    o_out_x    <= r_x1;
                    o_out_y    <= r_y1;
                end
                EM_ORIGIN: begin
                    o_out_kind <= OUT_MOVE;
                    o_out_x    <= '0;
                    o_out_y    <= '0;
                end
                EM_LINE: begin
                    o_out_kind <= OUT_LINE;
                    o_out_x    <= r_x1;
                    o_out_y    <= r_y1;
                end
                default: begin
                    o_out_kind <= OUT_LINE;
                    o_out_x    <= pt_x;
                    o_out_y    <= pt_y;
                end
            endcase
        end
    end

    assign o_status.kind         = r_kind;
    assign o_status.needs_origin = r_needs;
    assign o_status.out_free     = !o_valid || !i_stall;
    assign o_status.cross_done   = (r_e == pts_last);
    assign o_status.sat          = r_sat;
    assign o_status.k_pass       = (r_lhs[LHS_W-1:EPS4_SH] >= CMP_W'(r_rhs));
    assign o_status.k_at_max     = (r_k == maxs);
    assign o_status.mac_done     = (r_mi == pts_last);
    assign o_status.div_done     = (r_dcnt == DCNT_W'(CB - 1));
    assign o_status.j_at_n       = (r_j == nseg);

endmodule
`default_nettype wire

### sv/path_curve_flattener_top.sv
// Move, line and close are decoded and emitted. A curve runs cross multiply and
// accumulate per shoelace term; area, m2, x, lhs multiply, lhs sum; per tested
// sample count (up to the maximum) k square, k4, rhs, compare; the denominator;
// per emitted point the weights, a MAC per control point, bit-serial division
// and the emit. One request is in work at a time; the result register lets the
// next be taken. Reset is synchronous, active low: state clears.
`default_nettype none
module path_curve_flattener_top import pcf_pkg::*; #(
    parameter int COORD_BITS        = COORD_BITS_DEF,
    parameter int FRAC_BITS         = FRAC_BITS_DEF,
    parameter int QUAD_MAX_SAMPLES  = QUAD_MAX_DEF,
    parameter int CUBIC_MAX_SAMPLES = CUBIC_MAX_DEF,
    parameter int AREA_LIMIT        = AREA_LIMIT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [PADDR_W-1:0]           paddr,
    input  wire logic [PDATA_W-1:0]           pwdata,
    output logic [PDATA_W-1:0]                prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [2:0]                   i_kind,
    input  wire logic signed [COORD_BITS-1:0] i_p1_x,
    input  wire logic signed [COORD_BITS-1:0] i_p1_y,
    input  wire logic signed [COORD_BITS-1:0] i_p2_x,
    input  wire logic signed [COORD_BITS-1:0] i_p2_y,
    input  wire logic signed [COORD_BITS-1:0] i_p3_x,
    input  wire logic signed [COORD_BITS-1:0] i_p3_y,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_out_kind,
    output logic signed [COORD_BITS-1:0]      o_out_x,
    output logic signed [COORD_BITS-1:0]      o_out_y,
    output logic                              o_last
);

    logic [EPS_W-1:0] r_epsilon;
    logic             reg_sel;
    t_cmd             cmd;
    t_status          status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_EPSILON);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= EPS_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_epsilon <= pwdata[EPS_W-1:0];
        end
    end

    assign prdata = reg_sel ? PDATA_W'(r_epsilon) : '0;

    pcf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pcf_dp #(
        .COORD_BITS        (COORD_BITS),
        .FRAC_BITS         (FRAC_BITS),
        .QUAD_MAX_SAMPLES  (QUAD_MAX_SAMPLES),
        .CUBIC_MAX_SAMPLES (CUBIC_MAX_SAMPLES),
        .AREA_LIMIT        (AREA_LIMIT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_epsilon  (r_epsilon),
        .i_kind     (i_kind),
        .i_p1_x     (i_p1_x),
        .i_p1_y     (i_p1_y),
        .i_p2_x     (i_p2_x),
        .i_p2_y     (i_p2_y),
        .i_p3_x     (i_p3_x),
        .i_p3_y     (i_p3_y),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_kind (o_out_kind),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_last     (o_last)
    );

endmodule
`default_nettype wire

### sv/pcf_checker.sv
`default_nettype none
module pcf_checker import pcf_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic [1:0]                   o_out_kind,
    input wire logic signed [COORD_BITS-1:0] o_out_x,
    input wire logic signed [COORD_BITS-1:0] o_out_y,
    input wire logic                         o_last
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_x) && $stable(o_out_y) && $stable(o_last))
        else $error("stalled result changed");

    // A close always stands alone at the origin and ends its request.
    a_close_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == OUT_CLOSE |-> o_out_x == '0 && o_out_y == '0 && o_last)
        else $error("malformed close result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

endmodule

bind path_curve_flattener_top pcf_checker #(.COORD_BITS(COORD_BITS)) u_pcf_checker (.*);
`default_nettype wire

### tb/tb_path_curve_flattener_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_path_curve_flattener_top;
    import pcf_pkg::*;

    localparam int CW = 24;
    localparam int SETTLE_CYCLES = 1500;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]           kind;
        logic signed [CW-1:0] p1x, p1y, p2x, p2y, p3x, p3y;
    } path_cmd_t;

    typedef struct {
        logic [1:0]           kind;
        logic signed [CW-1:0] x, y;
        logic                 last;
    } seg_out_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_kind = '0;
    logic signed [CW-1:0] i_p1_x = '0, i_p1_y = '0, i_p2_x = '0, i_p2_y = '0;
    logic signed [CW-1:0] i_p3_x = '0, i_p3_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_out_kind;
    logic signed [CW-1:0] o_out_x, o_out_y;
    logic o_last;

    path_curve_flattener_top DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    path_cmd_t cmd_queue[$];
    seg_out_t  flat_queue[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        was_taken = 1'b0;

    // Flattener state as the block should hold it.
    logic signed [CW-1:0] src_x = '0, src_y = '0;
    logic                 origin_pending = 1'b1;
    logic [8:0]           eps = 9'd256;

    function automatic void push_seg(logic [1:0] k, longint x, longint y);
        seg_out_t s;
        s.kind = k;
        s.x = x[CW-1:0];
        s.y = y[CW-1:0];
        s.last = 1'b0;
        flat_queue.push_back(s);
    endfunction

    function automatic int samples_for(longint s, int maxs);
        logic [127:0] area, m, lhs, rhs, k4;
        int best;
        best = 0;
        if (s < 0) s = -s;
        area = 128'(s >>> (2 * FRAC_BITS_DEF));
        if (area >= AREA_LIMIT_DEF) return maxs;
        m = 128'(maxs) * 128'(eps);
        lhs = area * m * m * m * m;
        for (int k = 1; k <= maxs; k++) begin
            k4 = 128'(256 * k);
            k4 = k4 * k4 * k4 * k4;
            rhs = 128'(AREA_LIMIT_DEF) * k4;
            if (lhs >= rhs) best = k;
        end
        return (best < 2) ? 2 : best;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint q;
        q = num + den / 2;
        if (q >= 0) return q / den;
        return -((-q + den - 1) / den);
    endfunction

    function automatic void flatten(path_cmd_t c);
        longint px[4], py[4];
        longint acc, den, a, b, sx, sy;
        longint w[4];
        int pts, nseg, prior_size;
        prior_size = flat_queue.size();
        px[0] = src_x; py[0] = src_y;
        px[1] = c.p1x; py[1] = c.p1y;
        px[2] = c.p2x; py[2] = c.p2y;
        px[3] = c.p3x; py[3] = c.p3y;
        if (c.kind == KIND_CLOSE) begin
            push_seg(OUT_CLOSE, 0, 0);
            origin_pending = 1'b1;
        end else if (c.kind == KIND_MOVE) begin
            push_seg(OUT_MOVE, px[1], py[1]);
            src_x = c.p1x; src_y = c.p1y;
            origin_pending = 1'b0;
        end else if (c.kind == KIND_LINE || c.kind == KIND_QUAD || c.kind == KIND_CUBIC) begin
            if (origin_pending) push_seg(OUT_MOVE, 0, 0);
            origin_pending = 1'b0;
            if (c.kind == KIND_LINE) begin
                push_seg(OUT_LINE, px[1], py[1]);
                src_x = c.p1x; src_y = c.p1y;
            end else begin
                pts = (c.kind == KIND_CUBIC) ? 4 : 3;
                acc = 0;
                for (int i = 0; i < pts; i++) begin
                    int nx;
                    nx = (i + 1 == pts) ? 0 : i + 1;
                    acc += px[i] * py[nx] - py[i] * px[nx];
                end
                nseg = samples_for(acc, (pts == 4) ? CUBIC_MAX_DEF : QUAD_MAX_DEF) - 1;
                den = (pts == 4) ? longint'(nseg) * nseg * nseg : longint'(nseg) * nseg;
                for (int j = 1; j <= nseg; j++) begin
                    a = nseg - j;
                    b = j;
                    if (pts == 4) begin
                        w[0] = a * a * a; w[1] = 3 * a * a * b;
                        w[2] = 3 * a * b * b; w[3] = b * b * b;
                    end else begin
                        w[0] = a * a; w[1] = 2 * a * b; w[2] = b * b; w[3] = 0;
                    end
                    sx = 0; sy = 0;
                    for (int i = 0; i < pts; i++) begin
                        sx += w[i] * px[i];
                        sy += w[i] * py[i];
                    end
                    push_seg(OUT_LINE, round_div(sx, den), round_div(sy, den));
                end
                src_x = px[pts-1][CW-1:0];
                src_y = py[pts-1][CW-1:0];
            end
        end
        if (flat_queue.size() > prior_size) flat_queue[flat_queue.size()-1].last = 1'b1;
    endfunction

    // Request side: accepted requests are predicted at the edge that takes them.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            path_cmd_t c;
            c.kind = i_kind;
            c.p1x = i_p1_x; c.p1y = i_p1_y;
            c.p2x = i_p2_x; c.p2y = i_p2_y;
            c.p3x = i_p3_x; c.p3y = i_p3_y;
            flatten(c);
            was_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || was_taken)) begin
            was_taken = 1'b0;
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                path_cmd_t c;
                c = cmd_queue.pop_front();
                i_kind <= c.kind;
                i_p1_x <= c.p1x; i_p1_y <= c.p1y;
                i_p2_x <= c.p2x; i_p2_y <= c.p2y;
                i_p3_x <= c.p3x; i_p3_y <= c.p3y;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (flat_queue.size() == 0) begin
                $display("%0t: unexpected result kind=%0d x=%0d y=%0d last=%0d",
                         $time, o_out_kind, o_out_x, o_out_y, o_last);
                errors++;
            end else begin
                seg_out_t e;
                e = flat_queue.pop_front();
                if (o_out_kind !== e.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, e.kind, o_out_kind);
                    errors++;
                end
                if (o_out_x !== e.x) begin
                    $display("%0t: x expected %0d actual %0d", $time, e.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== e.y) begin
                    $display("%0t: y expected %0d actual %0d", $time, e.y, o_out_y);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last, o_last);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 55) return CW'($urandom_range(12000) - 6000);
        if (r < 80) return CW'($urandom_range(200000) - 100000);
        return CW'($urandom);
    endfunction

    function automatic path_cmd_t make_cmd(logic [2:0] k);
        path_cmd_t c;
        c.kind = k;
        c.p1x = rand_coord(); c.p1y = rand_coord();
        c.p2x = rand_coord(); c.p2y = rand_coord();
        c.p3x = rand_coord(); c.p3y = rand_coord();
        return c;
    endfunction

    function automatic path_cmd_t pts_cmd(logic [2:0] k, int v1, int v2, int v3);
        path_cmd_t c;
        c.kind = k;
        c.p1x = CW'(v1); c.p1y = CW'(v2);
        c.p2x = CW'(v2); c.p2y = CW'(v3);
        c.p3x = CW'(v3); c.p3y = CW'(v1);
        return c;
    endfunction

    task automatic queue_paths(int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            int r;
            r = $urandom_range(99);
            if (r < 80) begin
                // A well-formed subpath: move, a few segments, usually a close.
                int segs;
                segs = $urandom_range(6, 1);
                cmd_queue.push_back(make_cmd(KIND_MOVE));
                for (int i = 0; i < segs; i++)
                    cmd_queue.push_back(make_cmd(3'($urandom_range(3, 1))));
                if ($urandom_range(3) != 0) cmd_queue.push_back(make_cmd(KIND_CLOSE));
                sent += segs + 2;
            end else if (r < 95) begin
                cmd_queue.push_back(make_cmd(3'($urandom_range(4))));
                sent++;
            end else begin
                cmd_queue.push_back(make_cmd(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO))));
            end
        end
    endtask

    task automatic drain();
        // Checked at the clock so that a request being driven is never missed.
        while (!(cmd_queue.size() == 0 && !i_valid && flat_queue.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [8:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= PADDR_W'({REG_EPSILON, 2'b00});
        pwdata <= PDATA_W'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        eps = v;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a line first gets the origin move, then extremes and every kind.
        cmd_queue.push_back(pts_cmd(KIND_LINE, 8388607, -8388608, 0));
        cmd_queue.push_back(pts_cmd(KIND_MOVE, -8388608, 8388607, -1));
        cmd_queue.push_back(pts_cmd(KIND_QUAD, 8388607, 8388607, -8388608));
        cmd_queue.push_back(pts_cmd(KIND_CUBIC, -8388608, 8388607, 8388607));
        cmd_queue.push_back(pts_cmd(KIND_MOVE, 0, 0, 0));
        cmd_queue.push_back(pts_cmd(KIND_QUAD, 256, 512, 0));
        cmd_queue.push_back(pts_cmd(KIND_CUBIC, 2560, -2560, 5120));
        cmd_queue.push_back(pts_cmd(KIND_CUBIC, 0, 0, 0));
        cmd_queue.push_back(pts_cmd(KIND_CLOSE, 7, 7, 7));
        cmd_queue.push_back(pts_cmd(KIND_QUAD, 4000, -3000, 1500));
        cmd_queue.push_back(pts_cmd(KIND_CLOSE, 0, 0, 0));
        cmd_queue.push_back(pts_cmd(KIND_CUBIC, 18000, -18000, 9000));
        cmd_queue.push_back(pts_cmd(KIND_SPARE_LO, 1, 2, 3));
        cmd_queue.push_back(pts_cmd(KIND_SPARE_HI, -1, -2, -3));
        cmd_queue.push_back(pts_cmd(KIND_CLOSE, 0, 0, 0));
        cmd_queue.push_back(pts_cmd(KIND_MOVE, -5, 5, 0));
        cmd_queue.push_back(pts_cmd(KIND_LINE, -1, 1, 0));
        cmd_queue.push_back(pts_cmd(KIND_QUAD, 100000, -100000, 3));
        drain();

        write_eps(9'd0);
        queue_paths(50);
        cmd_queue.push_back(pts_cmd(KIND_CUBIC, 8388607, -8388608, 8388607));
        drain();

        write_eps(9'd256);
        send_idle_pct = 85;
        queue_paths(70);
        drain();

        write_eps(9'd128);
        send_idle_pct = 0; recv_stall_pct = 85;
        queue_paths(60);
        drain();

        write_eps(9'd37);
        send_idle_pct = 34; recv_stall_pct = 34;
        queue_paths(60);
        drain();

        write_eps(9'd200);
        send_idle_pct = 0; recv_stall_pct = 0;
        queue_paths(60);
        drain();

        if (errors == 0 && flat_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
